/* hdl/irclft_pkg.sv */
`default_nettype none

package irclft_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxLenW  = 10;
  // length counter holds the saturation value itself
  localparam int unsigned LenW     = MaxLenW + 1;
  localparam logic [LenW-1:0]    LenCap    = LenW'(1024);
  localparam logic [MaxLenW-1:0] MaxLenRst = MaxLenW'(512);

  // special characters
  localparam logic [ByteW-1:0] ChEot   = 8'h04;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;

  typedef enum logic [2:0] {
    FLD_PREFIX  = 3'd0,
    FLD_COMMAND = 3'd1,
    FLD_ARG     = 3'd2,
    FLD_TRAIL   = 3'd3,
    FLD_SEP     = 3'd4
  } field_e;

  typedef enum logic [5:0] {
    PH_LINE_START = 6'b000001,
    PH_PREFIX     = 6'b000010,
    PH_CMD_START  = 6'b000100,
    PH_COMMAND    = 6'b001000,
    PH_ARGS       = 6'b010000,
    PH_TRAIL      = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    field_e           byte_field;
    logic             arg_start;
    logic             line_end;
    logic             line_status;
    logic             malformed;
    logic             trail_present;
  } result_t;

endpackage

`default_nettype wire

/* hdl/irclft_byte_if.sv */
`default_nettype none

interface irclft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* hdl/irclft_result_if.sv */
`default_nettype none

interface irclft_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] byte_field;
  logic       arg_start;
  logic       line_end;
  logic       line_status;
  logic       malformed;
  logic       trail_present;

  modport source (
    output valid, output out_byte, output byte_valid, output byte_field,
    output arg_start, output line_end, output line_status, output malformed,
    output trail_present, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input byte_field,
    input arg_start, input line_end, input line_status, input malformed,
    input trail_present, output ready
  );
endinterface

`default_nettype wire

/* hdl/irclft_cfg_if.sv */
`default_nettype none

interface irclft_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] max_line_length;

  modport source (output valid, output max_line_length, input ready);
  modport sink   (input valid, input max_line_length, output ready);
endinterface

`default_nettype wire

/* hdl/irclft_parse.sv */
`default_nettype none

module irclft_parse (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire logic [irclft_pkg::ByteW-1:0]   byte_i,
  input  wire logic [irclft_pkg::MaxLenW-1:0] max_len_i,
  output irclft_pkg::result_t                 res_o
);
  import irclft_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  held_byte_q, held_byte_d;
  logic              held_valid_q, held_valid_d;
  logic              last_cr_q, last_cr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              mal_q, mal_d;
  logic              trail_q, trail_d;
  logic              in_arg_q, in_arg_d;

  // classification of the held byte
  phase_e            cls_phase;
  field_e            cls_field;
  logic              cls_arg_start;
  logic              cls_mal;
  logic              cls_trail;
  logic              cls_in_arg;
  logic              held_white;
  logic              at_cmd_start;

  assign held_white = (held_byte_q == ChSpace)
                   || ((held_byte_q >= ChTab) && (held_byte_q <= ChCr));
  assign at_cmd_start = (phase_q == PH_LINE_START) || (phase_q == PH_CMD_START);

  always_comb begin
    cls_phase     = phase_q;
    cls_field     = FLD_SEP;
    cls_arg_start = 1'b0;
    cls_mal       = mal_q;
    cls_trail     = trail_q;
    cls_in_arg    = in_arg_q;
    if ((phase_q == PH_LINE_START) && (held_byte_q == ChColon)) begin
      cls_phase = PH_PREFIX;
    end else if (phase_q == PH_PREFIX) begin
      if (held_byte_q == ChSpace) begin
        cls_phase = PH_CMD_START;
      end else begin
        cls_field = FLD_PREFIX;
      end
    end else if (phase_q == PH_TRAIL) begin
      cls_field = FLD_TRAIL;
    end else begin
      if (at_cmd_start && held_white) begin
        cls_mal = 1'b1;
      end
      if (held_byte_q == ChColon) begin
        cls_trail = 1'b1;
        cls_phase = PH_TRAIL;
      end else if (held_byte_q == ChSpace) begin
        cls_in_arg = 1'b0;
        cls_phase  = PH_ARGS;
      end else if (at_cmd_start || (phase_q == PH_COMMAND)) begin
        cls_field = FLD_COMMAND;
        cls_phase = PH_COMMAND;
      end else begin
        cls_field     = FLD_ARG;
        cls_arg_start = ~in_arg_q;
        cls_in_arg    = 1'b1;
        cls_phase     = PH_ARGS;
      end
    end
  end

  // per-byte step: discard, line end, or release of the held byte
  always_comb begin
    phase_d      = phase_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    last_cr_d    = last_cr_q;
    len_d        = len_q;
    mal_d        = mal_q;
    trail_d      = trail_q;
    in_arg_d     = in_arg_q;
    res_o        = '0;
    res_o.byte_field = FLD_PREFIX;
    if (byte_i == ChEot) begin
      last_cr_d = 1'b0;
    end else if (byte_i == ChLf) begin
      if (last_cr_q) begin
        res_o.line_end      = 1'b1;
        res_o.line_status   = (len_q > {1'b0, max_len_i});
        res_o.malformed     = mal_q;
        res_o.trail_present = trail_q;
        phase_d      = PH_LINE_START;
        held_byte_d  = '0;
        held_valid_d = 1'b0;
        last_cr_d    = 1'b0;
        len_d        = '0;
        mal_d        = 1'b0;
        trail_d      = 1'b0;
        in_arg_d     = 1'b0;
      end
    end else begin
      if (held_valid_q) begin
        res_o.out_byte   = held_byte_q;
        res_o.byte_valid = 1'b1;
        res_o.byte_field = cls_field;
        res_o.arg_start  = cls_arg_start;
        phase_d  = cls_phase;
        mal_d    = cls_mal;
        trail_d  = cls_trail;
        in_arg_d = cls_in_arg;
        if (len_q < LenCap) begin
          len_d = len_q + LenW'(1);
        end
      end
      held_byte_d  = byte_i;
      held_valid_d = 1'b1;
      last_cr_d    = (byte_i == ChCr);
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LINE_START;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      last_cr_q    <= 1'b0;
      len_q        <= '0;
      mal_q        <= 1'b0;
      trail_q      <= 1'b0;
      in_arg_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      last_cr_q    <= last_cr_d;
      len_q        <= len_d;
      mal_q        <= mal_d;
      trail_q      <= trail_d;
      in_arg_q     <= in_arg_d;
    end
  end

`ifndef SYNTHESIS
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.line_end) |=> (!held_valid_q && (phase_q == PH_LINE_START)
                                    && (len_q == '0)))
    else $error("line end did not restart the line");

  a_len_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenCap)
    else $error("line length above saturation");

  a_eot_keeps_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (byte_i == ChEot)) |=> ($stable(held_byte_q) && $stable(len_q)
                                       && !last_cr_q))
    else $error("discarded byte disturbed the held byte");

  a_release_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.byte_valid) |-> (held_valid_q && !res_o.line_end))
    else $error("byte released without a held byte");
`endif

endmodule

`default_nettype wire

/* hdl/irc_line_framer_tokenizer.sv */
`default_nettype none

// an accepted byte waits in the input register, and its result is held in the result register until taken
// throughput: one byte per cycle while the result sink keeps taking results, set by the parse state update
// the output register lets the next byte enter while a result waits to be taken
// reset (async, active low): line start, nothing held, max line length 512
module irc_line_framer_tokenizer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  irclft_cfg_if.sink      cfg_i,
  irclft_byte_if.sink     in_i,
  irclft_result_if.source out_o
);
  import irclft_pkg::*;

  logic [MaxLenW-1:0] max_len_q;
  logic               s1_valid_q, s1_valid_d;
  logic [ByteW-1:0]   s1_byte_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;
  result_t            step_res;
  logic               advance;
  logic               fire;
  logic               in_take;

  // configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_line_length;
    end
  end

  // handshake control
  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.data_byte;
    end
  end

  irclft_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (s1_byte_q),
    .max_len_i (max_len_q),
    .res_o     (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_q.out_byte;
  assign out_o.byte_valid    = out_q.byte_valid;
  assign out_o.byte_field    = out_q.byte_field;
  assign out_o.arg_start     = out_q.arg_start;
  assign out_o.line_end      = out_q.line_end;
  assign out_o.line_status   = out_q.line_status;
  assign out_o.malformed     = out_q.malformed;
  assign out_o.trail_present = out_q.trail_present;

`ifndef SYNTHESIS
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting result changed");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> !in_i.ready)
    else $error("input register would be overwritten");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("step result lost");
`endif

endmodule

`default_nettype wire

/* sim/irclft_token_checker.sv */
module irclft_token_checker (
  input  logic     clk_i,
  input  logic     rst_ni,
  irclft_cfg_if    cfg_mon,
  irclft_byte_if   byte_mon,
  irclft_result_if result_mon,
  output int       error_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import irclft_pkg::*;

  // tokens predicted for accepted bytes, oldest first
  result_t token_q[$];

  // shadow of the framer state
  logic [MaxLenW-1:0] max_len;
  phase_e             phase;
  logic [ByteW-1:0]   held_byte;
  field_e             held_field;
  logic               held_arg_start;
  logic               held_valid;
  logic               last_cr;
  logic [LenW-1:0]    line_len;
  logic               malformed_seen;
  logic               trail_seen;
  logic               in_arg;
  int                 result_idx;

  task automatic flag_error(input string msg);
    $display("%0t: token mismatch: %s", $time, msg);
    error_count_o++;
  endtask

  function automatic logic is_white(input logic [ByteW-1:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

  task automatic clear_line();
    phase          = PH_LINE_START;
    held_byte      = '0;
    held_valid     = 1'b0;
    last_cr        = 1'b0;
    line_len       = '0;
    malformed_seen = 1'b0;
    trail_seen     = 1'b0;
    in_arg         = 1'b0;
  endtask

  // tag a released byte and move the parse phase on
  task automatic tag_byte(input logic [ByteW-1:0] b);
    phase_e cur;
    cur = phase;
    held_arg_start = 1'b0;
    // leading colon opens the prefix
    if (cur == PH_LINE_START && b == ChColon) begin
      held_field = FLD_SEP;
      phase      = PH_PREFIX;
      return;
    end
    // prefix runs until a space, or to the end of the line
    if (cur == PH_PREFIX) begin
      if (b == ChSpace) begin
        held_field = FLD_SEP;
        phase      = PH_CMD_START;
      end else begin
        held_field = FLD_PREFIX;
      end
      return;
    end
    if (cur == PH_TRAIL) begin
      held_field = FLD_TRAIL;
      return;
    end
    // whitespace where the command should begin
    if (cur == PH_LINE_START || cur == PH_CMD_START) begin
      if (is_white(b)) malformed_seen = 1'b1;
      cur = PH_COMMAND;
    end
    if (b == ChColon) begin
      held_field = FLD_SEP;
      trail_seen = 1'b1;
      phase      = PH_TRAIL;
      return;
    end
    if (b == ChSpace) begin
      held_field = FLD_SEP;
      in_arg     = 1'b0;
      phase      = PH_ARGS;
      return;
    end
    if (cur == PH_COMMAND) begin
      held_field = FLD_COMMAND;
      phase      = PH_COMMAND;
      return;
    end
    held_field     = FLD_ARG;
    held_arg_start = !in_arg;
    in_arg         = 1'b1;
    phase          = PH_ARGS;
  endtask

  // expected token for one accepted byte
  task automatic tokenize(input logic [ByteW-1:0] b, output result_t r);
    r = '0;
    // end-of-transmission byte is dropped and breaks a pending cr
    if (b == ChEot) begin
      last_cr = 1'b0;
      return;
    end
    // lf closes the line only straight after a cr, otherwise it vanishes
    if (b == ChLf) begin
      if (last_cr) begin
        r.line_end      = 1'b1;
        r.line_status   = (line_len > LenW'(max_len));
        r.malformed     = malformed_seen;
        r.trail_present = trail_seen;
        clear_line();
      end
      return;
    end
    // release the held byte, keep the new one back
    if (held_valid) begin
      tag_byte(held_byte);
      r.out_byte   = held_byte;
      r.byte_valid = 1'b1;
      r.byte_field = held_field;
      r.arg_start  = held_arg_start;
      if (line_len < LenCap) line_len++;
    end
    held_byte  = b;
    held_valid = 1'b1;
    last_cr    = (b == ChCr);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d: %s is %0h, expected %0h", result_idx, name, got, want));
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      max_len        = MaxLenRst;
      held_field     = FLD_PREFIX;
      held_arg_start = 1'b0;
      clear_line();
      token_q.delete();
      result_idx = 0;
    end else begin
      // result transaction against the oldest prediction
      if (result_mon.valid && result_mon.ready) begin
        got.out_byte      = result_mon.out_byte;
        got.byte_valid    = result_mon.byte_valid;
        got.byte_field    = field_e'(result_mon.byte_field);
        got.arg_start     = result_mon.arg_start;
        got.line_end      = result_mon.line_end;
        got.line_status   = result_mon.line_status;
        got.malformed     = result_mon.malformed;
        got.trail_present = result_mon.trail_present;
        if (token_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no byte outstanding", result_idx));
        end else begin
          want = token_q.pop_front();
          check_field("out_byte", got.out_byte, want.out_byte);
          check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
          check_field("byte_field", 8'(got.byte_field), 8'(want.byte_field));
          check_field("arg_start", 8'(got.arg_start), 8'(want.arg_start));
          check_field("line_end", 8'(got.line_end), 8'(want.line_end));
          check_field("line_status", 8'(got.line_status), 8'(want.line_status));
          check_field("malformed", 8'(got.malformed), 8'(want.malformed));
          check_field("trail_present", 8'(got.trail_present), 8'(want.trail_present));
        end
        result_idx++;
      end
      // register write transaction
      if (cfg_mon.valid && cfg_mon.ready) max_len = cfg_mon.max_line_length;
      // byte transaction
      if (byte_mon.valid && byte_mon.ready) begin
        tokenize(byte_mon.data_byte, want);
        token_q.insert(token_q.size(), want);
      end
    end
    pending_o = token_q.size();
  end

endmodule

/* sim/irc_line_framer_tokenizer_tb.sv */
module irc_line_framer_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irclft_pkg::*;

  localparam logic [ByteW-1:0] ChVt = 8'h0B;
  localparam logic [ByteW-1:0] ChFf = 8'h0C;
  localparam int HoldOffCycles = 80;
  localparam int PhaseBytes    = 90;
  localparam int RandomPhases  = 8;
  localparam int SettleCycles  = 10;

  // framing corner cases: prefix, command, args, trail, dropped and lone bytes
  localparam logic [ByteW-1:0] DirectedBytes [24] = '{
    ChColon, "p", ChSpace, "X", ChSpace, "a", ChSpace, ChColon, "t", ChCr, ChLf,
    ChSpace, ChEot, ChLf, 8'h00, 8'hFF, ChCr, ChEot, ChLf, ChCr, ChLf,
    ChCr, ChCr, ChLf
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_off_req = 1'b0;
  int   tx_gap_pct = 0;
  int   rx_stall_pct = 0;
  int   token_errors;
  int   tokens_pending;
  logic [ByteW-1:0] line_q[$];

  irclft_cfg_if    cfg_bus ();
  irclft_byte_if   in_bus ();
  irclft_result_if out_bus ();

  irc_line_framer_tokenizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  irclft_token_checker token_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_mon       (cfg_bus),
    .byte_mon      (in_bus),
    .result_mon    (out_bus),
    .error_count_o (token_errors),
    .pending_o     (tokens_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap, short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [ByteW-1:0] word_char();
    logic [ByteW-1:0] c;
    if ($urandom_range(15) == 0) return 8'($urandom_range(255, 128));
    do c = 8'($urandom_range(8'h7E, 8'h21)); while (c == ChColon);
    return c;
  endfunction

  function automatic logic [ByteW-1:0] white_char();
    case ($urandom_range(4))
      0: return ChSpace;
      1: return ChTab;
      2: return ChVt;
      3: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] junk_byte();
    case ($urandom_range(6))
      0: return ChCr;
      1: return ChLf;
      2: return ChEot;
      3: return ChColon;
      4: return ChSpace;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // append one byte to the line under construction
  task automatic add_byte(input logic [ByteW-1:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  // one byte transaction, then an optional gap
  task automatic push_byte(input logic [ByteW-1:0] b);
    int gap;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) push_byte(line_q[i]);
    line_q.delete();
  endtask

  // stop offering bytes until every token has come out
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (tokens_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [MaxLenW-1:0] v);
    cfg_bus.valid           <= 1'b1;
    cfg_bus.max_line_length <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // well-formed message with random content and occasional damage
  task automatic build_message();
    if ($urandom_range(1)) begin
      add_byte(ChColon);
      repeat ($urandom_range(8, 1)) add_byte(word_char());
      // sometimes the prefix never gets its space
      if ($urandom_range(9) != 0) add_byte(ChSpace);
    end
    if ($urandom_range(9) == 0) add_byte(white_char());
    if ($urandom_range(3) == 0) begin
      repeat (3) add_byte(8'($urandom_range(8'h39, 8'h30)));
    end else begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(8'h5A, 8'h41)));
    end
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(2, 1)) add_byte(ChSpace);
      repeat ($urandom_range(6, 1)) add_byte(word_char());
    end
    if ($urandom_range(99) < 40) begin
      add_byte(ChSpace);
      add_byte(ChColon);
      repeat ($urandom_range(12)) add_byte(8'($urandom_range(8'h7E, 8'h20)));
    end
    // stray eot or lone lf somewhere in the line
    if ($urandom_range(9) == 0) begin
      line_q.insert(int'($urandom_range(line_q.size())), $urandom_range(1) ? ChEot : ChLf);
    end
    add_byte(ChCr);
    // eot between cr and lf keeps the line open
    if ($urandom_range(19) == 0) add_byte(ChEot);
    add_byte(ChLf);
  endtask

  task automatic build_line();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_message();
    end else if (kind < 90) begin
      repeat ($urandom_range(20, 1)) add_byte(8'($urandom_range(255)));
      add_byte(ChCr);
      add_byte(ChLf);
    end else begin
      repeat ($urandom_range(12, 1)) add_byte(junk_byte());
    end
  endtask

  // command, space, trail filler: n content bytes before the cr
  task automatic build_long_line(input int n);
    repeat (6) add_byte(8'($urandom_range(8'h5A, 8'h41)));
    add_byte(ChSpace);
    add_byte(ChColon);
    repeat (n - 8) add_byte(8'($urandom_range(8'h7E, 8'h20)));
    add_byte(ChCr);
    add_byte(ChLf);
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        stall = pick_gap(rx_stall_pct);
        if (stall == 0) begin
          out_bus.ready <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // byte source and verdict
  initial begin
    int sent;
    logic [MaxLenW-1:0] max_len;
    rst_ni                  <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.max_line_length <= '0;
    in_bus.valid            <= 1'b0;
    in_bus.data_byte        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines at the reset length limit
    foreach (DirectedBytes[i]) push_byte(DirectedBytes[i]);
    drain();

    // random phases, each with its own limit and idling profile
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: max_len = 10'd1023;
        1: max_len = 10'd1;
        2: max_len = MaxLenW'($urandom_range(12, 2));
        3: max_len = MaxLenW'($urandom_range(40, 13));
        4: max_len = MaxLenW'($urandom_range(1023, 1));
        6: max_len = 10'd1;
        default: max_len = MaxLenW'($urandom_range(25, 5));
      endcase
      set_max_len(max_len);
      tx_gap_pct   = (ph == 0 || ph == 3) ? 0 : $urandom_range(50, 10);
      rx_stall_pct = (ph == 0) ? 0 : $urandom_range(50, 10);
      // long output stall while bytes keep coming
      if (ph == 3) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PhaseBytes) begin
        build_line();
        sent += line_q.size();
        send_line();
      end
      drain();
    end

    // widest limit: one line past the 10-bit range of the length limit
    set_max_len(10'd1023);
    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    build_long_line(1030);
    send_line();
    drain();

    repeat (SettleCycles) @(posedge clk_i);
    if (token_errors == 0 && tokens_pending == 0) begin
      $display("irc_line_framer_tokenizer verification clean");
    end else begin
      $display("irc_line_framer_tokenizer verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("irc_line_framer_tokenizer verification failed");
    $finish;
  end

endmodule
